// ===== rtl/mlpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mlpq_pkg: shared types and constants of the multilevel priority ready queue
// Request and response structures, operation codes and pointer widths.
// ----------------------------------------------------------------------------
package mlpq_pkg;

  localparam int TASKS_DEF  = 64;
  localparam int LEVELS_DEF = 32;

  localparam int FUNC_W = 2;
  localparam int ID_W   = 6;
  localparam int PRIO_W = 5;
  localparam int PTR_W  = 7;
  localparam int CNT_W  = 7;

  localparam logic [PTR_W-1:0] NONE_ID = 7'd127;

  localparam logic [FUNC_W-1:0] FUNC_ADD     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP     = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REQUEUE = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   task_id;
    logic [PRIO_W-1:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]  popped_id;
    logic             popped_valid;
    logic             empty_error;
    logic [CNT_W-1:0] queued_count;
  } rsp_t;

endpackage

// ===== rtl/multilevel_priority_ready_queue.sv =====
// ----------------------------------------------------------------------------
// multilevel_priority_ready_queue: FIFO of task ids per priority level
// Each level is a linked list kept in a level memory (head and tail) and a
// next-pointer memory, with a presence bitmap that selects the top level.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single response
// appears on out_rsp for one cycle with out_strobe, in the first cycle in
// which busy is low again, and must be taken then. An add runs through ST_ADD,
// a pop through ST_POP1 and ST_POP2, an add-then-pop through ST_ADD, ST_POP0,
// ST_POP1 and ST_POP2; a pop of an empty queue, an unused code or an add of an
// out-of-range id answers from idle. The states follow from the registered
// reads of both memories: a pop reads the level entry, then its head's next
// pointer, before writing back. The bitmap marks which level entries hold data.
module multilevel_priority_ready_queue #(
  parameter int TASKS  = mlpq_pkg::TASKS_DEF,
  parameter int LEVELS = mlpq_pkg::LEVELS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  mlpq_pkg::req_t in_req,
  output logic           out_strobe,
  output mlpq_pkg::rsp_t out_rsp
);

  localparam int NEXT_DEPTH = (TASKS < 64) ? TASKS : 64;
  localparam int NIDX_W     = $clog2(NEXT_DEPTH);
  localparam int LVL_DEPTH  = (LEVELS < 32) ? LEVELS : 32;
  localparam int LVL_W      = $clog2(LVL_DEPTH);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ADD  = 3'd1;
  localparam logic [2:0] ST_POP0 = 3'd2;
  localparam logic [2:0] ST_POP1 = 3'd3;
  localparam logic [2:0] ST_POP2 = 3'd4;

  typedef struct packed {
    logic [mlpq_pkg::PTR_W-1:0] head;
    logic [mlpq_pkg::PTR_W-1:0] tail;
  } lvl_ent_t;

  function automatic logic [LVL_W-1:0] sat_level(input logic [mlpq_pkg::PRIO_W-1:0] p);
    logic [LVL_W-1:0] r;
    if (32'(p) >= LVL_DEPTH) begin
      r = LVL_W'(LVL_DEPTH - 1);
    end else begin
      r = LVL_W'(p);
    end
    return r;
  endfunction

  function automatic logic [LVL_W-1:0] top_level(input logic [LVL_DEPTH-1:0] m);
    logic [LVL_W-1:0] r;
    r = '0;
    for (int i = 0; i < LVL_DEPTH; i++) begin
      if (m[i]) begin
        r = LVL_W'(i);
      end
    end
    return r;
  endfunction

  lvl_ent_t                   lvl_mem [LVL_DEPTH];
  logic [mlpq_pkg::PTR_W-1:0] next_mem [NEXT_DEPTH];

  logic [2:0]                 state_r, state_nxt;
  logic [LVL_DEPTH-1:0]       present_r, present_nxt;
  logic [mlpq_pkg::CNT_W-1:0] count_r, count_nxt;
  mlpq_pkg::req_t             req_r, req_nxt;
  logic [LVL_W-1:0]           pop_lvl_r, pop_lvl_nxt;
  logic                       out_strobe_r, out_strobe_nxt;
  mlpq_pkg::rsp_t             out_rsp_r, out_rsp_nxt;

  lvl_ent_t                   lm_rdata_r;
  logic [mlpq_pkg::PTR_W-1:0] nm_rdata_r;

  logic                       lm_re, lm_we;
  logic [LVL_W-1:0]           lm_raddr, lm_waddr;
  lvl_ent_t                   lm_wdata;
  logic                       nm_re, nm_we;
  logic [NIDX_W-1:0]          nm_raddr, nm_waddr;
  logic [mlpq_pkg::PTR_W-1:0] nm_wdata;

  logic [LVL_W-1:0]           top_lvl;
  logic [LVL_W-1:0]           add_lvl;
  logic                       in_is_add, in_is_pop, in_id_ok;

  assign top_lvl   = top_level(present_r);
  assign add_lvl   = sat_level(req_r.priority_req);
  assign in_is_add = (in_req.func == mlpq_pkg::FUNC_ADD) ||
                     (in_req.func == mlpq_pkg::FUNC_REQUEUE);
  assign in_is_pop = (in_req.func == mlpq_pkg::FUNC_POP) ||
                     (in_req.func == mlpq_pkg::FUNC_REQUEUE);
  assign in_id_ok  = (32'(in_req.task_id) < TASKS);

  always_comb begin
    state_nxt      = state_r;
    present_nxt    = present_r;
    count_nxt      = count_r;
    req_nxt        = req_r;
    pop_lvl_nxt    = pop_lvl_r;
    out_strobe_nxt = 1'b0;
    out_rsp_nxt    = out_rsp_r;
    lm_re          = 1'b0;
    lm_raddr       = top_lvl;
    lm_we          = 1'b0;
    lm_waddr       = add_lvl;
    lm_wdata       = lm_rdata_r;
    nm_re          = 1'b0;
    nm_raddr       = NIDX_W'(lm_rdata_r.head);
    nm_we          = 1'b0;
    nm_waddr       = NIDX_W'(in_req.task_id);
    nm_wdata       = mlpq_pkg::NONE_ID;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt                  = in_req;
          out_rsp_nxt              = '0;
          out_rsp_nxt.queued_count = count_r;
          priority if (in_is_add && in_id_ok) begin
            nm_we     = 1'b1;
            lm_re     = 1'b1;
            lm_raddr  = sat_level(in_req.priority_req);
            state_nxt = ST_ADD;
          end else if (in_is_pop && (present_r != '0)) begin
            lm_re       = 1'b1;
            pop_lvl_nxt = top_lvl;
            state_nxt   = ST_POP1;
          end else begin
            out_strobe_nxt          = 1'b1;
            out_rsp_nxt.empty_error = in_is_pop;
          end
        end
      end
      ST_ADD: begin
        lm_we = 1'b1;
        if (present_r[add_lvl]) begin
          nm_we         = 1'b1;
          nm_waddr      = NIDX_W'(lm_rdata_r.tail);
          nm_wdata      = mlpq_pkg::PTR_W'(req_r.task_id);
          lm_wdata.head = lm_rdata_r.head;
        end else begin
          lm_wdata.head = mlpq_pkg::PTR_W'(req_r.task_id);
        end
        lm_wdata.tail        = mlpq_pkg::PTR_W'(req_r.task_id);
        present_nxt[add_lvl] = 1'b1;
        count_nxt            = count_r + mlpq_pkg::CNT_W'(1);
        if (req_r.func == mlpq_pkg::FUNC_REQUEUE) begin
          state_nxt = ST_POP0;
        end else begin
          state_nxt                = ST_IDLE;
          out_strobe_nxt           = 1'b1;
          out_rsp_nxt              = '0;
          out_rsp_nxt.queued_count = count_nxt;
        end
      end
      ST_POP0: begin
        lm_re       = 1'b1;
        pop_lvl_nxt = top_lvl;
        state_nxt   = ST_POP1;
      end
      ST_POP1: begin
        nm_re     = 1'b1;
        state_nxt = ST_POP2;
      end
      ST_POP2: begin
        lm_we    = 1'b1;
        lm_waddr = pop_lvl_r;
        if (nm_rdata_r == mlpq_pkg::NONE_ID) begin
          lm_wdata.head          = mlpq_pkg::NONE_ID;
          lm_wdata.tail          = mlpq_pkg::NONE_ID;
          present_nxt[pop_lvl_r] = 1'b0;
        end else begin
          lm_wdata.head = nm_rdata_r;
          lm_wdata.tail = lm_rdata_r.tail;
        end
        count_nxt                = count_r - mlpq_pkg::CNT_W'(1);
        state_nxt                = ST_IDLE;
        out_strobe_nxt           = 1'b1;
        out_rsp_nxt.popped_id    = lm_rdata_r.head[mlpq_pkg::ID_W-1:0];
        out_rsp_nxt.popped_valid = 1'b1;
        out_rsp_nxt.empty_error  = 1'b0;
        out_rsp_nxt.queued_count = count_nxt;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (lm_we) begin
      lvl_mem[lm_waddr] <= lm_wdata;
    end
    if (lm_re) begin
      lm_rdata_r <= lvl_mem[lm_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (nm_we) begin
      next_mem[nm_waddr] <= nm_wdata;
    end
    if (nm_re) begin
      nm_rdata_r <= next_mem[nm_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      present_r    <= '0;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      present_r    <= present_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    pop_lvl_r <= pop_lvl_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_rsp    = out_rsp_r;

endmodule

// ===== rtl/mlpq_check.sv =====
// ----------------------------------------------------------------------------
// mlpq_check: port-level checks of the multilevel priority ready queue
// Watches requests and responses on the top-level ports and is bound there.
// ----------------------------------------------------------------------------
module mlpq_check (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input mlpq_pkg::req_t in_req,
  input logic           out_strobe,
  input mlpq_pkg::rsp_t out_rsp
);

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_strobe))
    else $error("accepted request neither held the block busy nor responded");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("response strobed while the block is still busy");

  a_pop_or_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_rsp.popped_valid && out_rsp.empty_error))
    else $error("response claims both a popped id and an empty queue");

  a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_rsp.popped_valid) |-> (out_rsp.popped_id == '0))
    else $error("popped id is nonzero without a pop");

  a_add_no_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req.func == mlpq_pkg::FUNC_ADD)) |=>
      (!out_strobe || !out_rsp.empty_error))
    else $error("add request reported an empty queue");

endmodule

bind multilevel_priority_ready_queue mlpq_check u_mlpq_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_req     (in_req),
  .out_strobe (out_strobe),
  .out_rsp    (out_rsp)
);
